// ===== rtl/core/ptt_pkg.sv =====
// Package for the periodic timer table: item types, slot word layout,
// result codes, operation codes and sequencer states. No dependencies.

package ptt_pkg;

   localparam int NUM_SLOTS_DEF = 32;
   localparam int TICK_MS_DEF   = 100;
   localparam int NUM_DESTS_DEF = 5;

   localparam int ID_W     = 16;
   localparam int DELAY_W  = 16;
   localparam int DEST_W   = 3;
   localparam int MASK_W   = 5;
   localparam int RELOAD_W = 10;

   // Largest reload count a slot can hold, at the width of a delay.
   localparam logic [DELAY_W-1:0] RELOAD_MAX = DELAY_W'(1023);

   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_KILL = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [2:0] KIND_SET_OK    = 3'd0;
   localparam logic [2:0] KIND_NO_FREE   = 3'd1;
   localparam logic [2:0] KIND_BAD_DEST  = 3'd2;
   localparam logic [2:0] KIND_KILL_OK   = 3'd3;
   localparam logic [2:0] KIND_KILL_MISS = 3'd4;
   localparam logic [2:0] KIND_EXPIRY    = 3'd5;
   localparam logic [2:0] KIND_TICK_DONE = 3'd6;

   typedef struct packed {
      logic [1:0]         operation;
      logic [ID_W-1:0]    timer_id;
      logic [DELAY_W-1:0] delay_ms;
      logic [DEST_W-1:0]  dest_layer;
      logic [MASK_W-1:0]  queue_full_mask;
   } req_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [ID_W-1:0]   out_timer_id;
      logic [DEST_W-1:0] out_dest;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]     ident;
      logic [DEST_W-1:0]   dest;
      logic [RELOAD_W-1:0] reload;
      logic [RELOAD_W-1:0] remaining;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET_SCAN,
      ST_SET_WAIT,
      ST_WALK,
      ST_FIN
   } state_type;

endpackage

// ===== rtl/core/ptt_tick_div.sv =====
// Reload count unit: turns a delay in milliseconds into a count of ticks by a
// reciprocal multiply, clamped to the range 1 to RELOAD_MAX. Uses ptt_pkg.

module ptt_tick_div
   import ptt_pkg::*;
#(
   parameter int TICK_MS = TICK_MS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DELAY_W-1:0]  dividend,
   output logic                busy,
   output logic [RELOAD_W-1:0] ticks
);

   // The reciprocal is rounded up at a scale of DELAY_W plus the bits of the
   // tick period, which makes the shifted product the exact floor quotient for
   // every delay that fits in DELAY_W bits. It fits in DELAY_W + 1 bits.
   localparam int PRE     = $clog2(TICK_MS);
   localparam int SHIFT   = DELAY_W + PRE;
   localparam int RECIP_W = DELAY_W + 1;
   localparam int PROD_W  = DELAY_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic               busy_ff, busy_in;
   logic [DELAY_W-1:0] dvd_ff, dvd_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DELAY_W:0]   quo;

   // The delay is captured at start and multiplied in the following cycle.
   assign busy_in = start;
   assign dvd_in  = start ? dividend : dvd_ff;
   assign prod_in = busy_ff ? PROD_W'(dvd_ff) * PROD_W'(RECIP) : prod_ff;
   assign quo     = (DELAY_W + 1)'(prod_ff[PROD_W-1:SHIFT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      dvd_ff  <= dvd_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      if (quo == '0) begin
         ticks = RELOAD_W'(1);
      end else if (quo > {1'b0, RELOAD_MAX}) begin
         ticks = RELOAD_MAX[RELOAD_W-1:0];
      end else begin
         ticks = quo[RELOAD_W-1:0];
      end
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/core/periodic_timer_table_unit.sv =====
// Top level of the periodic timer table: slot memory, active flags and the
// sequencer that serves set, kill and tick items. Uses ptt_pkg, ptt_tick_div.
//
// The block takes one request item at a time on the req_ channel and answers
// on the rsp_ channel. A set or a kill gives exactly one result item. A tick
// gives one expiry item for each slot that fires and can deliver, then one
// finished item; the final result item of every request carries last high.
// Operation code 3 is dropped without a result.
// A kill or a tick walks the slot memory, one slot per cycle, reading ahead
// one slot while the previous one is written back; its final result is
// registered in ST_FIN once the walk ends, sooner for a kill that hits.
// A set scans the active flags one slot per cycle while a reciprocal multiply
// turns the delay into ticks; its result is registered in ST_FIN after the
// slot write, or after the scan alone for a full table or a bad destination.
// The next request is accepted the cycle after that, even while the last
// result still waits in the output register. When the receiver stalls with a
// result pending, the walk freezes on the slot that wants to emit and resumes
// when the register frees up. Reset clears all active flags at once; the slot
// memory itself needs no clearing, since a slot is only used after a set has
// written it.

module periodic_timer_table_unit
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int TICK_MS   = TICK_MS_DEF,
   parameter int NUM_DESTS = NUM_DESTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Slot index width and walk counter width (the counter also holds NUM_SLOTS).
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam logic [CW-1:0]     LAST_WALK = CW'(NUM_SLOTS);
   localparam logic [DEST_W:0]   DEST_LIM  = (DEST_W + 1)'(NUM_DESTS);

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   logic [CW-1:0]        walk_ff, walk_in;
   logic [SW-1:0]        walk_idx;
   logic                 v2_ff, v2_in;
   logic [SW-1:0]        p2_ff, p2_in;
   logic [SW-1:0]        free_ff, free_in;
   logic [2:0]           fin_kind_ff, fin_kind_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // Slot memory: one word per slot, one write and one registered read a cycle.
   slot_type slot_ram [NUM_SLOTS];
   slot_type rdata_ff;
   logic          mem_re;
   logic [SW-1:0] mem_ra;
   logic          mem_we;
   logic [SW-1:0] mem_wa;
   slot_type      mem_wd;

   logic                div_start;
   logic                div_busy;
   logic [RELOAD_W-1:0] div_ticks;

   logic out_busy;
   logic dest_ok;

   ptt_tick_div #(
      .TICK_MS(TICK_MS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(req_data.delay_ms),
      .busy    (div_busy),
      .ticks   (div_ticks)
   );

   assign walk_idx  = walk_ff[SW-1:0];
   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign dest_ok   = {1'b0, item_ff.dest_layer} < DEST_LIM;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic              s2_active;
      logic              is_full;
      logic [7:0]        full_wide;
      logic              hold;
      logic              matched;

      state_in     = state_ff;
      item_in      = item_ff;
      walk_in      = walk_ff;
      v2_in        = v2_ff;
      p2_in        = p2_ff;
      free_in      = free_ff;
      fin_kind_in  = fin_kind_ff;
      active_in    = active_ff;
      rsp_valid_in = out_busy;
      rsp_in       = rsp_ff;
      mem_re       = 1'b0;
      mem_ra       = walk_idx;
      mem_we       = 1'b0;
      mem_wa       = p2_ff;
      mem_wd       = rdata_ff;
      div_start    = 1'b0;
      hold         = 1'b0;
      matched      = 1'b0;
      s2_active    = active_ff[p2_ff];
      full_wide    = {{(8 - MASK_W){1'b0}}, item_ff.queue_full_mask};
      // A destination without a bit in the mask never counts as full.
      is_full      = ({1'b0, rdata_ff.dest} < (DEST_W + 1)'(MASK_W)) &&
                     full_wide[rdata_ff.dest];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               walk_in = '0;
               v2_in   = 1'b0;
               case (req_data.operation)
                  OP_SET: begin
                     div_start = 1'b1;
                     state_in  = ST_SET_SCAN;
                  end
                  OP_KILL, OP_TICK: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SET_SCAN: begin
            // Look for the lowest free slot, one flag per cycle.
            if (walk_ff == LAST_WALK) begin
               fin_kind_in = KIND_NO_FREE;
               state_in    = ST_FIN;
            end else if (!active_ff[walk_idx]) begin
               free_in = walk_idx;
               if (dest_ok) begin
                  state_in = ST_SET_WAIT;
               end else begin
                  fin_kind_in = KIND_BAD_DEST;
                  state_in    = ST_FIN;
               end
            end else begin
               walk_in = walk_ff + CW'(1);
            end
         end

         ST_SET_WAIT: begin
            if (!div_busy) begin
               mem_we           = 1'b1;
               mem_wa           = free_ff;
               mem_wd.ident     = item_ff.timer_id;
               mem_wd.dest      = item_ff.dest_layer;
               mem_wd.reload    = div_ticks;
               mem_wd.remaining = div_ticks;
               active_in[free_ff] = 1'b1;
               fin_kind_in      = KIND_SET_OK;
               state_in         = ST_FIN;
            end
         end

         ST_WALK: begin
            // Second stage: the slot whose word arrived from memory.
            if (v2_ff && s2_active) begin
               if (item_ff.operation == OP_KILL) begin
                  if (rdata_ff.ident == item_ff.timer_id) begin
                     matched           = 1'b1;
                     active_in[p2_ff]  = 1'b0;
                  end
               end else if (rdata_ff.remaining > RELOAD_W'(1)) begin
                  mem_we           = 1'b1;
                  mem_wd.remaining = rdata_ff.remaining - RELOAD_W'(1);
               end else if (is_full) begin
                  // Destination full: retry on the next tick.
                  mem_we           = 1'b1;
                  mem_wd.remaining = RELOAD_W'(1);
               end else if (out_busy) begin
                  hold = 1'b1;
               end else begin
                  mem_we              = 1'b1;
                  mem_wd.remaining    = rdata_ff.reload;
                  rsp_valid_in        = 1'b1;
                  rsp_in.kind         = KIND_EXPIRY;
                  rsp_in.out_timer_id = rdata_ff.ident;
                  rsp_in.out_dest     = rdata_ff.dest;
                  rsp_in.last         = 1'b0;
               end
            end

            if (matched) begin
               v2_in       = 1'b0;
               fin_kind_in = KIND_KILL_OK;
               state_in    = ST_FIN;
            end else if (!hold) begin
               // First stage: issue the read of the next slot.
               if (walk_ff != LAST_WALK) begin
                  mem_re  = 1'b1;
                  walk_in = walk_ff + CW'(1);
                  v2_in   = 1'b1;
                  p2_in   = walk_idx;
               end else begin
                  v2_in = 1'b0;
                  if (!v2_ff) begin
                     fin_kind_in = (item_ff.operation == OP_KILL) ? KIND_KILL_MISS
                                                                  : KIND_TICK_DONE;
                     state_in    = ST_FIN;
                  end
               end
            end
         end

         ST_FIN: begin
            if (!out_busy) begin
               rsp_valid_in        = 1'b1;
               rsp_in.kind         = fin_kind_ff;
               rsp_in.out_timer_id = (item_ff.operation == OP_TICK) ? '0
                                                                    : item_ff.timer_id;
               rsp_in.out_dest     = '0;
               rsp_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         v2_ff        <= v2_in;
      end
      item_ff     <= item_in;
      walk_ff     <= walk_in;
      p2_ff       <= p2_in;
      free_ff     <= free_in;
      fin_kind_ff <= fin_kind_in;
      rsp_ff      <= rsp_in;
   end

   // The walk never writes the slot it is reading in the same cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_ram[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= slot_ram[mem_ra];
      end
   end

endmodule

// ===== tb/ptt_timer_monitor.sv =====
// Monitor for the periodic timer table testbench: it watches both channels,
// predicts the result items of every accepted request item and checks them.
// Depends on ptt_pkg for the item types, operation codes and result codes.

module ptt_timer_monitor
   import ptt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      awaited_count,
   output int      request_count,
   output int      result_count,
   output int      expiry_count
);

   localparam int NUM_SLOTS = NUM_SLOTS_DEF;
   localparam int TICK_MS   = TICK_MS_DEF;
   localparam int NUM_DESTS = NUM_DESTS_DEF;

   // Shadow copy of the timer slots.
   bit                  slot_on     [NUM_SLOTS];
   logic [ID_W-1:0]     slot_ident  [NUM_SLOTS];
   logic [DEST_W-1:0]   slot_dest   [NUM_SLOTS];
   logic [RELOAD_W-1:0] slot_reload [NUM_SLOTS];
   logic [RELOAD_W-1:0] slot_left   [NUM_SLOTS];

   rsp_type awaited_results[$];

   function automatic rsp_type timer_result(logic [2:0] kind, logic [ID_W-1:0] id,
                                            logic [DEST_W-1:0] dest, logic last);
      rsp_type r;
      r.kind         = kind;
      r.out_timer_id = id;
      r.out_dest     = dest;
      r.last         = last;
      return r;
   endfunction

   // Unknown bits in the result count as a mismatch.
   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   // Applies one request item to the shadow slots and queues its result items.
   task automatic serve_timer_request(input req_type item);
      int          free_slot;
      int unsigned ticks;
      bit          hit;
      free_slot = -1;
      hit       = 1'b0;
      case (item.operation)
         OP_SET: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (!slot_on[s]) begin
                  free_slot = s;
                  break;
               end
            end
            if (free_slot < 0) begin
               awaited_results.push_back(timer_result(KIND_NO_FREE, item.timer_id, '0, 1'b1));
            end else if (item.dest_layer >= NUM_DESTS) begin
               awaited_results.push_back(timer_result(KIND_BAD_DEST, item.timer_id, '0, 1'b1));
            end else begin
               ticks = item.delay_ms / TICK_MS;
               if (ticks == 0) ticks = 1;
               if (ticks > RELOAD_MAX) ticks = RELOAD_MAX;
               slot_on[free_slot]     = 1'b1;
               slot_ident[free_slot]  = item.timer_id;
               slot_dest[free_slot]   = item.dest_layer;
               slot_reload[free_slot] = RELOAD_W'(ticks);
               slot_left[free_slot]   = RELOAD_W'(ticks);
               awaited_results.push_back(timer_result(KIND_SET_OK, item.timer_id, '0, 1'b1));
            end
         end
         OP_KILL: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (slot_on[s] && slot_ident[s] == item.timer_id) begin
                  slot_on[s] = 1'b0;
                  hit        = 1'b1;
                  break;
               end
            end
            awaited_results.push_back(timer_result(hit ? KIND_KILL_OK : KIND_KILL_MISS,
                                                   item.timer_id, '0, 1'b1));
         end
         OP_TICK: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (!slot_on[s]) continue;
               if (slot_left[s] > 1) begin
                  slot_left[s] = slot_left[s] - 1'b1;
               end else if (slot_dest[s] < MASK_W && item.queue_full_mask[slot_dest[s]]) begin
                  // The queue is full, so the expiry is held back to the next tick.
                  slot_left[s] = 1;
               end else begin
                  slot_left[s] = slot_reload[s];
                  awaited_results.push_back(timer_result(KIND_EXPIRY, slot_ident[s],
                                                         slot_dest[s], 1'b0));
                  expiry_count++;
               end
            end
            awaited_results.push_back(timer_result(KIND_TICK_DONE, '0, '0, 1'b1));
         end
         default: begin
            // The unused operation code is dropped without a result.
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) slot_on[s] = 1'b0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (awaited_results.size() == 0) begin
               error_count++;
               $display("%0t: result item with none awaited, expected nothing, got kind %0d id %h",
                        $time, rsp_data.kind, rsp_data.out_timer_id);
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
               check_field("out_timer_id", 32'(want.out_timer_id),
                           32'(rsp_data.out_timer_id));
               check_field("out_dest", 32'(want.out_dest), 32'(rsp_data.out_dest));
               check_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         if (req_valid && !req_stall) begin
            request_count++;
            serve_timer_request(req_data);
         end
      end
      awaited_count <= awaited_results.size();
   end

endmodule

// ===== tb/periodic_timer_table_unit_tb.sv =====
// Testbench top for the periodic timer table: drives request items, stalls
// the result channel and gives the verdict. Uses ptt_pkg, ptt_timer_monitor.

module periodic_timer_table_unit_tb;
   import ptt_pkg::*;

   // The operation code that the block must drop without a result.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Long enough to cover a tick walk over every slot, so this drains any late item.
   localparam int DRAIN_CYCLES = 40;
   // No correct run goes this long without a single item accepted.
   localparam int QUIET_LIMIT  = 2000;
   localparam int POOL_SIZE    = 12;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int awaited_count;
   int request_count;
   int result_count;
   int expiry_count;

   // Idling on both channels is switched per phase of the run.
   bit idle_on = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;

   // Timer identifiers are mostly drawn from a small pool, so that kills hit
   // live timers and duplicate identifiers show up.
   logic [ID_W-1:0] id_pool [POOL_SIZE];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   periodic_timer_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ptt_timer_monitor u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .awaited_count (awaited_count),
      .request_count (request_count),
      .result_count  (result_count),
      .expiry_count  (expiry_count)
   );

   // The receiver stalls in bursts of random length while idling is on. A
   // new burst may follow right after the previous one ends.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: a stretch without any accepted item means the block hung, or
   // that results are still awaited that will never come.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item accepted for %0d cycles", $time, QUIET_LIMIT);
         $display("[periodic_timer_table_unit] ERROR");
         $finish;
      end
   end

   function automatic req_type make_request(logic [1:0] op, logic [ID_W-1:0] id,
                                            logic [DELAY_W-1:0] delay,
                                            logic [DEST_W-1:0] dest,
                                            logic [MASK_W-1:0] mask);
      req_type item;
      item.operation       = op;
      item.timer_id        = id;
      item.delay_ms        = delay;
      item.dest_layer      = dest;
      item.queue_full_mask = mask;
      return item;
   endfunction

   // Builds one random request item. The weights are percentages for set,
   // kill and tick; what is left over goes to the unused code. Fields that an
   // operation ignores still carry random noise.
   function automatic req_type random_request(int unsigned set_w, int unsigned kill_w,
                                              int unsigned tick_w);
      req_type     item;
      int unsigned roll;
      item.operation       = OP_UNUSED;
      item.timer_id        = ($urandom_range(0, 99) < 85) ?
                             id_pool[$urandom_range(0, POOL_SIZE-1)] : ID_W'($urandom);
      item.delay_ms        = DELAY_W'($urandom);
      item.dest_layer      = DEST_W'($urandom);
      item.queue_full_mask = MASK_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < set_w) begin
         item.operation = OP_SET;
         // Short delays keep the reload counts low, so expiries come often.
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: item.delay_ms = DELAY_W'($urandom_range(0, 499));
            7, 8:                item.delay_ms = DELAY_W'($urandom_range(500, 3000));
            default:             item.delay_ms = DELAY_W'($urandom);
         endcase
         if ($urandom_range(0, 19) < 18) begin
            item.dest_layer = DEST_W'($urandom_range(0, NUM_DESTS_DEF-1));
         end else begin
            item.dest_layer = DEST_W'($urandom_range(NUM_DESTS_DEF, 7));
         end
      end else if (roll < set_w + kill_w) begin
         item.operation = OP_KILL;
      end else if (roll < set_w + kill_w + tick_w) begin
         item.operation = OP_TICK;
         // Mostly no queue is full; sometimes some or all of them are, which
         // holds expiries back for a retry on a later tick.
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: item.queue_full_mask = '0;
            9:             item.queue_full_mask = '1;
            default:       item.queue_full_mask = MASK_W'($urandom);
         endcase
      end
      return item;
   endfunction

   // Offers one request item, after a random gap when idling is on, and
   // returns at the clock edge that accepts it. Valid stays high on return so
   // that back to back items need no gap.
   task automatic send_request(input req_type item);
      int unsigned gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with no idling on either side. It starts on an empty
      // table: a tick gives only the finished marker and a kill finds nothing.
      send_request(make_request(OP_TICK, '0, '0, '0, '0));
      send_request(make_request(OP_KILL, 16'hFFFF, '0, '0, '0));
      // Zero delay is raised to the minimum of one tick; the longest delay
      // lands on the highest destination.
      send_request(make_request(OP_SET, 16'h0000, 16'd0, 3'd0, '0));
      send_request(make_request(OP_SET, 16'hFFFF, 16'hFFFF, 3'd4, '0));
      // Two timers with the same identifier, one and two ticks long.
      send_request(make_request(OP_SET, 16'h1234, 16'd199, 3'd1, '0));
      send_request(make_request(OP_SET, 16'h1234, 16'd200, 3'd2, '0));
      send_request(make_request(OP_SET, 16'h55AA, 16'd100, 3'd3, '0));
      // Destinations past the last queue are refused and take no slot.
      send_request(make_request(OP_SET, 16'hBEEF, 16'd300, 3'd5, '0));
      send_request(make_request(OP_SET, 16'hBEEF, 16'd300, 3'd6, '0));
      send_request(make_request(OP_SET, 16'hBEEF, 16'd300, 3'd7, '0));
      // The unused code with every field bit high must be ignored.
      send_request(make_request(OP_UNUSED, '1, '1, '1, '1));
      // All queues full: nothing is emitted, due timers wait at one tick.
      send_request(make_request(OP_TICK, '1, '1, '1, '1));
      send_request(make_request(OP_TICK, '0, '0, '0, '0));
      send_request(make_request(OP_TICK, '0, '0, '0, 5'b00010));
      // A kill frees only the lowest of the duplicates, then the other one.
      send_request(make_request(OP_KILL, 16'h1234, '0, '0, '0));
      send_request(make_request(OP_TICK, '0, '0, '0, '0));
      send_request(make_request(OP_KILL, 16'h1234, '0, '0, '0));
      send_request(make_request(OP_KILL, 16'h1234, '0, '0, '0));
      send_request(make_request(OP_TICK, '0, '0, '0, 5'b10101));

      // Mixed traffic with idling on both sides.
      idle_on = 1'b1;
      repeat (50) send_request(random_request(40, 20, 35));

      // Mostly sets, so that the table fills up and further sets find no
      // free slot, with and without a bad destination.
      repeat (40) send_request(random_request(85, 0, 15));
      send_request(make_request(OP_SET, id_pool[3], 16'd250, 3'd7, '0));
      send_request(make_request(OP_SET, id_pool[4], 16'd250, 3'd0, '0));

      // The last part runs without idling: mostly kills and ticks, so the
      // full table drains while it keeps firing.
      idle_on = 1'b0;
      repeat (57) send_request(random_request(15, 45, 35));
      req_valid <= 1'b0;

      // Wait for every awaited result, then give the block time to show any
      // result item that should not come.
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d request items of every kind through the timer table.", request_count);
      $display("Checked %0d result items, %0d of them expiries.", result_count, expiry_count);
      if (error_count == 0) begin
         $display("[periodic_timer_table_unit] OK");
      end else begin
         $display("[periodic_timer_table_unit] ERROR");
      end
      $finish;
   end

endmodule
